FILE: rtl/imufp_pkg.sv
// Shared types and constants for the IMU frame parser with sum check.
package imufp_pkg;

	typedef logic signed [15:0] sample_t;
	typedef logic [7:0] byte_t;

	localparam byte_t HDR_BYTE   = 8'h55;
	localparam byte_t TYPE_FIRST = 8'h51;
	localparam byte_t TYPE_LAST  = 8'h54;

	// Byte position of the checksum within a frame (bytes 0..9 are summed).
	localparam logic [3:0] SUM_LEN     = 4'd10;
	localparam logic [3:0] FIRST_PAY   = 4'd2;
	localparam logic [3:0] LAST_HELD   = 4'd7;
	localparam int         HELD_BYTES  = 6;
	localparam int         N_SAMPLES   = 9;

	localparam logic [1:0] GRP_ACCEL = 2'd0;
	localparam logic [1:0] GRP_RATE  = 2'd1;
	localparam logic [1:0] GRP_ANGLE = 2'd2;
	localparam logic [1:0] GRP_MAG   = 2'd3;

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_TYPE = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

endpackage

FILE: rtl/imu_frame_parser_sum_check_unit.sv
// Top level of the IMU frame parser with header, type byte and sum check.
//
// Input channel: one received serial byte per item on rx_byte, in_valid/in_ready.
// The parser hunts for header 0x55, takes a type byte 0x51..0x54, eight payload
// bytes and a checksum byte. A frame whose 8-bit sum of the first ten bytes
// matches the checksum updates the acceleration, angular rate or angle triple
// (type 0x54 updates nothing) and emits one result item on out_valid/out_ready:
// group_updated and the full nine-value snapshot. Other bytes give no result.
// The result for a checksum byte is registered: the accepted byte sits in the
// input register, then the parse step writes the result register.
// Throughput: one byte per cycle while no result waits on a stalled receiver;
// the single parse step between input and result register sets this figure.
// When the receiver stalls with a result pending, the input register holds at
// most one more byte, and in_ready stays low until the result is taken.
// Reset clears the parser to hunting and all nine stored samples to zero; no
// result is pending after reset.
module imu_frame_parser_sum_check_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  imufp_pkg::byte_t   rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         group_updated,
	output imufp_pkg::sample_t accel_x,
	output imufp_pkg::sample_t accel_y,
	output imufp_pkg::sample_t accel_z,
	output imufp_pkg::sample_t rate_x,
	output imufp_pkg::sample_t rate_y,
	output imufp_pkg::sample_t rate_z,
	output imufp_pkg::sample_t roll_angle,
	output imufp_pkg::sample_t pitch_angle,
	output imufp_pkg::sample_t yaw_angle
);
	import imufp_pkg::*;

	// input register
	logic    valid_s1;
	byte_t   byte_s1;

	// parser state
	phase_t     phase_q;
	logic [3:0] count_q;
	byte_t      sum_q;
	logic [1:0] kind_q;
	byte_t      held_q [HELD_BYTES];
	sample_t    store_q [N_SAMPLES];

	// result register
	logic       out_valid_q;
	logic [1:0] grp_q;
	sample_t    snap_q [N_SAMPLES];

	logic       advance;
	logic       emit;
	logic       type_ok;
	logic [2:0] held_idx;
	phase_t     phase_d;
	logic [3:0] count_d;
	byte_t      sum_d;
	sample_t    store_d [N_SAMPLES];
	sample_t    word [3];

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign type_ok  = (byte_s1 >= TYPE_FIRST) && (byte_s1 <= TYPE_LAST);
	assign held_idx = 3'(count_q - FIRST_PAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// word n of the payload, little-endian from held bytes 2n and 2n+1
	always_comb begin
		for (int n = 0; n < 3; n++) begin
			word[n] = sample_t'({held_q[2*n+1], held_q[2*n]});
		end
	end

	always_comb begin
		phase_d = PH_HUNT;
		count_d = '0;
		sum_d   = '0;
		emit    = 1'b0;
		for (int i = 0; i < N_SAMPLES; i++) begin
			store_d[i] = store_q[i];
		end
		case (phase_q)
			PH_TYPE: begin
				if (type_ok) begin
					phase_d = PH_BODY;
					count_d = FIRST_PAY;
					sum_d   = sum_q + byte_s1;
				end
			end
			PH_BODY: begin
				if (count_q != SUM_LEN) begin
					phase_d = PH_BODY;
					count_d = count_q + 4'd1;
					sum_d   = sum_q + byte_s1;
				end else if (sum_q == byte_s1) begin
					emit = 1'b1;
					case (kind_q)
						GRP_ACCEL: begin
							for (int n = 0; n < 3; n++) store_d[n] = word[n];
						end
						GRP_RATE: begin
							for (int n = 0; n < 3; n++) store_d[3+n] = word[n];
						end
						GRP_ANGLE: begin
							for (int n = 0; n < 3; n++) store_d[6+n] = word[n];
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				// hunting; a rejected type byte never lands here as a header
				if (byte_s1 == HDR_BYTE) begin
					phase_d = PH_TYPE;
					count_d = 4'd1;
					sum_d   = byte_s1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			sum_q   <= '0;
			kind_q  <= GRP_ACCEL;
			for (int i = 0; i < N_SAMPLES; i++) begin
				store_q[i] <= '0;
			end
		end else if (advance) begin
			phase_q <= phase_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			if (phase_q == PH_TYPE && type_ok) begin
				kind_q <= 2'(byte_s1 - TYPE_FIRST);
			end
			for (int i = 0; i < N_SAMPLES; i++) begin
				store_q[i] <= store_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && phase_q == PH_BODY && count_q >= FIRST_PAY
				&& count_q <= LAST_HELD) begin
			held_q[held_idx] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			grp_q <= kind_q;
			for (int i = 0; i < N_SAMPLES; i++) begin
				snap_q[i] <= store_d[i];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign group_updated = grp_q;
	assign accel_x       = snap_q[0];
	assign accel_y       = snap_q[1];
	assign accel_z       = snap_q[2];
	assign rate_x        = snap_q[3];
	assign rate_y        = snap_q[4];
	assign rate_z        = snap_q[5];
	assign roll_angle    = snap_q[6];
	assign pitch_angle   = snap_q[7];
	assign yaw_angle     = snap_q[8];

`ifndef SYNTHESIS
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("parser phase not one-hot");

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> (count_q >= FIRST_PAY && count_q <= SUM_LEN))
		else $error("byte count out of range while gathering");

	a_result_from_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(phase_q) == PH_BODY && $past(count_q) == SUM_LEN))
		else $error("result raised outside a checksum byte");

	a_hunt_stays: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_HUNT && byte_s1 != HDR_BYTE |=> phase_q == PH_HUNT)
		else $error("left hunting without a header byte");
`endif

endmodule
